// ===== rtl/fslm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fslm_pkg: shared types and constants of the font slot LRU mounter
// Field widths, status codes, the sequencer state type and the structs that
// pass between the controller and the slot cells.
// ----------------------------------------------------------------------------
package fslm_pkg;

   localparam int ID_W     = 6;
   localparam int NAME_W   = 24;
   localparam int SIZE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ID  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_FONT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TOUCH
   } state_type;

   // Carried from cell to cell: has a lower slot already matched the key,
   // and has a lower slot already been found holding the oldest rank.
   typedef struct packed {
      logic hit;
      logic lru;
   } link_type;

   // Update command broadcast to every cell during the touch step.
   typedef struct packed {
      logic en;
      logic fill;
   } touch_type;

   // A name is at most three characters; bytes after the first zero are cleared.
   function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] res;
      res = raw;
      if (raw[7:0] == 8'd0) begin
         res = '0;
      end else if (raw[15:8] == 8'd0) begin
         res = {16'd0, raw[7:0]};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/fslm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fslm_cell: one mount slot
// Holds the valid bit, stored name and recency rank of a slot, compares the
// key against its name and forwards the search chain to the next slot.
// ----------------------------------------------------------------------------
module fslm_cell #(
   parameter int SLOT_COUNT = 8,
   parameter int INDEX      = 0
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [fslm_pkg::NAME_W-1:0]         key,
   input  fslm_pkg::link_type                  link_in,
   output fslm_pkg::link_type                  link_out,
   output logic                                hit_first,
   output logic                                lru_first,
   output logic [$clog2(SLOT_COUNT)-1:0]       rank,
   input  fslm_pkg::touch_type                 touch,
   input  wire                                 touch_sel,
   input  wire  [$clog2(SLOT_COUNT)-1:0]       touch_rank
);
   import fslm_pkg::*;

   localparam int RANK_W = $clog2(SLOT_COUNT);

   logic              valid_ff, valid_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic              match;
   logic              oldest;

   assign match     = valid_ff && (name_ff == key);
   assign oldest    = (rank_ff == '0);
   assign hit_first = match && !link_in.hit;
   assign lru_first = oldest && !link_in.lru;
   assign link_out  = '{hit: link_in.hit | match, lru: link_in.lru | oldest};
   assign rank      = rank_ff;

   always_comb begin
      valid_in = valid_ff;
      name_in  = name_ff;
      rank_in  = rank_ff;
      if (touch.en) begin
         if (touch_sel) begin
            rank_in = RANK_W'(SLOT_COUNT - 1);
            if (touch.fill) begin
               valid_in = 1'b1;
               name_in  = key;
            end
         end else if (rank_ff > touch_rank) begin
            rank_in = rank_ff - RANK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= RANK_W'(INDEX);
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
      name_ff <= name_in;
   end

endmodule
`default_nettype wire

// ===== rtl/font_slot_lru_mounter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// font_slot_lru_mounter: fully associative font mount table with LRU refill
// Looks up a font name among the mount slots, refreshes its recency on a hit
// and mounts it in the least recently used slot on a miss.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high while busy is low. A successful
// one passes through capture, slot search and recency update; one that fails
// the id or existence check ends after capture and the check. The result is
// presented with rsp_strobe high for exactly one cycle and must be taken
// then, as the block cannot be stalled. busy is low again in the cycle that
// carries the result, so a new transaction may start there.
// ----------------------------------------------------------------------------
module font_slot_lru_mounter #(
   parameter int SLOT_COUNT = 8,
   parameter int FONT_COUNT = 64
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire  [fslm_pkg::ID_W-1:0]         req_font_id,
   input  wire  [fslm_pkg::NAME_W-1:0]       req_font_name,
   input  wire  [fslm_pkg::SIZE_W-1:0]       req_point_size,
   output logic                              rsp_strobe,
   output logic [fslm_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_do_mount,
   output logic [fslm_pkg::POS_W-1:0]        rsp_mount_position,
   output logic [fslm_pkg::SIZE_W-1:0]       rsp_size_out,
   output logic [fslm_pkg::NAME_W-1:0]       rsp_name_out
);
   import fslm_pkg::*;

   localparam int RANK_W = $clog2(SLOT_COUNT);

   state_type state_ff, state_in;

   logic [NAME_W-1:0]     key_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic                  bad_id_ff;
   logic                  absent_ff;
   logic [SLOT_COUNT-1:0] sel_ff, sel_in;
   logic [RANK_W-1:0]     sel_rank_ff, sel_rank_in;
   logic                  miss_ff;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_do_mount_ff, rsp_do_mount_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [SIZE_W-1:0]     rsp_size_ff, rsp_size_in;
   logic [NAME_W-1:0]     rsp_name_ff, rsp_name_in;

   link_type              link [SLOT_COUNT+1];
   logic [SLOT_COUNT-1:0] hit_first;
   logic [SLOT_COUNT-1:0] lru_first;
   logic [RANK_W-1:0]     rank [SLOT_COUNT];
   touch_type             touch;
   logic                  accept;
   logic                  capture_sel;
   logic                  hit_any;
   logic [RANK_W-1:0]     sel_idx;

   assign accept  = start && (state_ff == ST_IDLE);
   assign link[0] = '{hit: 1'b0, lru: 1'b0};
   assign hit_any = link[SLOT_COUNT].hit;

   genvar gi;
   generate
      for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_slot
         fslm_cell #(
            .SLOT_COUNT(SLOT_COUNT),
            .INDEX     (gi)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .key       (key_ff),
            .link_in   (link[gi]),
            .link_out  (link[gi+1]),
            .hit_first (hit_first[gi]),
            .lru_first (lru_first[gi]),
            .rank      (rank[gi]),
            .touch     (touch),
            .touch_sel (sel_ff[gi]),
            .touch_rank(sel_rank_ff)
         );
      end
   endgenerate

   // Chosen slot: lowest matching slot on a hit, the oldest slot otherwise.
   always_comb begin
      sel_in      = hit_any ? hit_first : lru_first;
      sel_rank_in = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (sel_in[i]) begin
            sel_rank_in = sel_rank_in | rank[i];
         end
      end
   end

   always_comb begin
      sel_idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (sel_ff[i]) begin
            sel_idx = sel_idx | RANK_W'(i);
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_CHECK;
         ST_CHECK: state_in = (bad_id_ff || absent_ff) ? ST_IDLE : ST_TOUCH;
         ST_TOUCH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      busy            = 1'b1;
      capture_sel     = 1'b0;
      touch           = '{en: 1'b0, fill: 1'b0};
      rsp_strobe_in   = 1'b0;
      rsp_status_in   = STATUS_OK;
      rsp_do_mount_in = 1'b0;
      rsp_pos_in      = '0;
      rsp_size_in     = '0;
      rsp_name_in     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_CHECK: begin
            capture_sel = 1'b1;
            if (bad_id_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_BAD_ID;
            end else if (absent_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_NO_FONT;
            end
         end
         ST_TOUCH: begin
            touch           = '{en: 1'b1, fill: miss_ff};
            rsp_strobe_in   = 1'b1;
            rsp_status_in   = STATUS_OK;
            rsp_do_mount_in = miss_ff;
            rsp_pos_in      = miss_ff ? POS_W'(sel_idx) + POS_W'(1) : '0;
            rsp_size_in     = size_ff;
            rsp_name_in     = key_ff;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      if (accept) begin
         key_ff    <= clean_name(req_font_name);
         size_ff   <= req_point_size;
         bad_id_ff <= ({3'd0, req_font_id} >= 9'(FONT_COUNT));
         absent_ff <= (req_font_name == '0) && (req_point_size == '0);
      end
      if (capture_sel) begin
         sel_ff      <= sel_in;
         sel_rank_ff <= sel_rank_in;
         miss_ff     <= !hit_any;
      end
      rsp_status_ff   <= rsp_status_in;
      rsp_do_mount_ff <= rsp_do_mount_in;
      rsp_pos_ff      <= rsp_pos_in;
      rsp_size_ff     <= rsp_size_in;
      rsp_name_ff     <= rsp_name_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_do_mount       = rsp_do_mount_ff;
   assign rsp_mount_position = rsp_pos_ff;
   assign rsp_size_out       = rsp_size_ff;
   assign rsp_name_out       = rsp_name_ff;

`ifndef SYNTHESIS
   // A result always leaves the sequencer back in idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // The touch step updates exactly one slot.
   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TOUCH) |-> $onehot(sel_ff))
      else $error("touched slot is not unique");

   // A failed transaction never reports a mount.
   a_fail_no_mount: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |->
         (!rsp_do_mount && (rsp_mount_position == '0)))
      else $error("mount reported on failure");

   // A mount always names a slot.
   a_mount_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_do_mount) |-> (rsp_mount_position != '0))
      else $error("mount without a position");
`endif

endmodule
`default_nettype wire
